// ===== sv/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values, state machine type.
// Used by sha256_byte_stream_hasher and sha256_ram.
`default_nettype none
package sha256_pkg;
    localparam int BufDepth = 64;
    localparam int RamDepthDefault = 16;
    localparam int RamWidthDefault = 32;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ===== sv/sha256_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on sha256_pkg for default sizes.
`default_nettype none
module sha256_ram #(
    parameter int Width = sha256_pkg::RamWidthDefault,
    parameter int Depth = sha256_pkg::RamDepthDefault
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/sha256_byte_stream_hasher.sv =====
// Channel | fields (low bit first)                           | handshake
// s_      | tdata: msg_byte[7:0]; tuser: byte_present, finish | tvalid/tready
// m_      | tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast: last_word
// A byte transfer lands in a 16x32 block RAM. The byte that fills a block holds s_tready
// low while the block is compressed: the schedule registers load from the RAM, 64 rounds
// run at one round a cycle, and a fold adds the result into the chaining words.
// Finish pads byte by byte (one or two compressions), then loads the output register
// and emits eight transfers.
// aresetn is synchronous; m_ stalls hold the output register and stop the block.
// Depends on sha256_pkg and sha256_ram.
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // msg_byte
    input  wire logic [1:0]  s_tuser,   // byte_present, finish
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word
    output logic [2:0]       m_tuser,   // word_index
    output logic             m_tlast
);
    sha256_pkg::state_t state_reg, state_next;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [23:0] part_reg;
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    logic [63:0] len_reg;
    logic        finish_reg;
    logic        mark_reg;
    logic        tail_reg;
    logic [6:0]  cnt_reg;
    logic [2:0]  oidx_reg;

    logic        we;
    logic [3:0]  waddr, raddr;
    logic [31:0] wdata, rdata;
    logic        put;
    logic [7:0]  put_byte;

    sha256_ram #(.Width(32), .Depth(16)) u_buf (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [31:0] s0, s1, wn, t1, t2, w_cur;
    always_comb begin
        s0 = sha256_pkg::ror(w_reg[1], 7) ^ sha256_pkg::ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha256_pkg::ror(w_reg[14], 17) ^ sha256_pkg::ror(w_reg[14], 19)
           ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = v_reg[7] + (sha256_pkg::ror(v_reg[4], 6) ^ sha256_pkg::ror(v_reg[4], 11)
           ^ sha256_pkg::ror(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::round_k(cnt_reg[5:0]) + w_cur;
        t2 = (sha256_pkg::ror(v_reg[0], 2) ^ sha256_pkg::ror(v_reg[0], 13)
           ^ sha256_pkg::ror(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        s_tready = (state_reg == sha256_pkg::ST_IDLE);
        put = 1'b0;
        put_byte = s_tdata;
        unique case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    put = s_tuser[0];
                    if (s_tuser[0] && fill_reg == 6'd63) begin
                        state_next = sha256_pkg::ST_LOAD;
                    end else if (s_tuser[1]) begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                put = 1'b1;
                if (!mark_reg) begin
                    put_byte = 8'h80;
                end else if (tail_reg) begin
                    put_byte = len_reg[8*(6'd63 - fill_reg) +: 8];
                end else begin
                    put_byte = 8'h00;
                end
                if (fill_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD: begin
                if (cnt_reg == 7'd16) begin
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (cnt_reg == 7'd63) begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD: begin
                if (!finish_reg) begin
                    state_next = sha256_pkg::ST_IDLE;
                end else if (tail_reg) begin
                    state_next = sha256_pkg::ST_OUT;
                end else begin
                    state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_OUT: begin
                if (m_tvalid && m_tready && oidx_reg == 3'd7) begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    assign we = put && (fill_reg[1:0] == 2'd3);
    assign waddr = fill_reg[5:2];
    assign wdata = {part_reg, put_byte};
    assign raddr = cnt_reg[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::ST_IDLE;
            fill_reg <= '0;
            total_reg <= '0;
            finish_reg <= 1'b0;
            mark_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg <= '0;
            oidx_reg <= '0;
            len_reg <= '0;
            m_tvalid <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha256_pkg::init_h(3'(i));
        end else begin
            state_reg <= state_next;
            if (put) begin
                part_reg <= {part_reg[15:0], put_byte};
                fill_reg <= fill_reg + 6'd1;
            end
            unique case (state_reg)
                sha256_pkg::ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_tvalid) begin
                        finish_reg <= s_tuser[1];
                        len_reg <= {total_reg + 61'(s_tuser[0]), 3'b000};
                        total_reg <= total_reg + 61'(s_tuser[0]);
                    end
                end
                sha256_pkg::ST_PAD: begin
                    cnt_reg <= '0;
                    mark_reg <= 1'b1;
                    if (fill_reg == 6'd55) tail_reg <= 1'b1;
                end
                sha256_pkg::ST_LOAD: begin
                    cnt_reg <= (cnt_reg == 7'd16) ? 7'd0 : cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0) begin
                        for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= rdata;
                    end
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                end
                sha256_pkg::ST_ROUND: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= (cnt_reg < 7'd48) ? wn : w_reg[0];
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                sha256_pkg::ST_FOLD: begin
                    cnt_reg <= '0;
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    oidx_reg <= '0;
                end
                default: ;
            endcase
            if (state_reg == sha256_pkg::ST_OUT) begin
                if (!m_tvalid) begin
                    m_tvalid <= 1'b1;
                    m_tdata <= h_reg[oidx_reg];
                    m_tuser <= oidx_reg;
                    m_tlast <= (oidx_reg == 3'd7);
                end else if (m_tready) begin
                    if (oidx_reg == 3'd7) begin
                        m_tvalid <= 1'b0;
                        for (int i = 0; i < 8; i++) h_reg[i] <= sha256_pkg::init_h(3'(i));
                        fill_reg <= '0;
                        total_reg <= '0;
                        finish_reg <= 1'b0;
                        mark_reg <= 1'b0;
                        tail_reg <= 1'b0;
                    end else begin
                        oidx_reg <= oidx_reg + 3'd1;
                        m_tdata <= h_reg[oidx_reg + 3'd1];
                        m_tuser <= oidx_reg + 3'd1;
                        m_tlast <= (oidx_reg == 3'd6);
                    end
                end
            end
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == sha256_pkg::ST_IDLE) else $error("ready outside idle");
    a_out_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == sha256_pkg::ST_OUT) else $error("output outside out");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("last flag mismatch");
    a_round_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sha256_pkg::ST_ROUND && cnt_reg == 7'd63 |=>
        state_reg == sha256_pkg::ST_FOLD) else $error("round count");
endmodule
`default_nettype wire

// ===== tb/sha256_stream_checker.sv =====
// Checker for sha256_byte_stream_hasher: watches both stream channels, computes
// the expected digests from accepted bytes and compares every result transfer.
// Depends on nothing but the port widths of the block.
module sha256_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] HINIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [60:0]  msg_len;
    digest_beat_t digest_q[$];

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = chain;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            chain[j] += v[j];
    endtask

    task automatic append_byte(logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 0)
            compress_block();
    endtask

    task automatic absorb_transfer(logic [7:0] b, logic present, logic fin);
        logic [63:0] bits;
        if (present) begin
            append_byte(b);
            msg_len++;
        end
        if (fin) begin
            bits = {msg_len, 3'b000};
            append_byte(8'h80);
            while (fill != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(bits[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{chain[i], 3'(i), i == 7});
            chain = HINIT;
            fill = 0;
            msg_len = 0;
        end
    endtask

    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            chain = HINIT;
            fill = 0;
            msg_len = 0;
            digest_q.delete();
            fail_count <= 0;
            pending_words <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest transfer %h idx %0d last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_tdata !== exp_beat.word || m_tuser !== exp_beat.index
                            || m_tlast !== exp_beat.last) begin
                        $display("%0t: expected %h idx %0d last %b, got %h idx %0d last %b",
                                 $time, exp_beat.word, exp_beat.index, exp_beat.last,
                                 m_tdata, m_tuser, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_transfer(s_tdata, s_tuser[0], s_tuser[1]);
            pending_words <= digest_q.size();
        end
    end
endmodule

// ===== tb/sha256_byte_stream_hasher_test.sv =====
// Testbench top for sha256_byte_stream_hasher: drives byte streams with random
// idling on both channels and reports the verdict from sha256_stream_checker.
// Depends on sha256_byte_stream_hasher and sha256_stream_checker.
module sha256_byte_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_words;
    int          cycle_count = 0;
    bit          calm = 1'b0;

    always #5 aclk = ~aclk;

    sha256_byte_stream_hasher uut (.*);

    sha256_stream_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 22);

    // hold each transfer until accepted; idle between transfers at random
    task automatic send_transfer(logic [7:0] b, logic present, logic fin);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= {fin, present};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_message(int len, logic trailing_empty);
        for (int i = 0; i < len; i++)
            send_transfer(8'($urandom), 1'b1, !trailing_empty && i == len - 1);
        if (trailing_empty || len == 0)
            send_transfer(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // empty message, single 0x00 and 0xff, "abc", empty items ignored
        send_transfer(8'h00, 1'b0, 1'b1);
        send_transfer(8'h00, 1'b1, 1'b1);
        send_transfer(8'hff, 1'b0, 1'b0);
        send_transfer(8'hff, 1'b1, 1'b1);
        send_transfer(8'h61, 1'b1, 1'b0);
        send_transfer(8'h62, 1'b1, 1'b0);
        send_transfer(8'h00, 1'b0, 1'b0);
        send_transfer(8'h63, 1'b1, 1'b1);
        send_transfer(8'h5a, 1'b0, 1'b1);
        // padding spills into a second block, no idling
        calm = 1'b1;
        send_message(56, 1'b1);
        calm = 1'b0;
        for (int m = 0; m < 8; m++) begin
            len = $urandom_range(6);
            if ($urandom_range(9) == 0)
                send_transfer(8'($urandom), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(1)));
        end
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
